// File: design/mmpmp_pkg.sv
// Package: shared widths, codes and limits for the masked max-plus matrix power block.
`timescale 1ns / 1ps
package mmpmp_pkg;
   localparam int MAX_SIZE   = 64;
   localparam int IDX_W      = $clog2(MAX_SIZE);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int CELLS      = MAX_SIZE * MAX_SIZE;
   localparam int VALUE_BITS = 48;
   localparam int WEIGHT_W   = 16;
   localparam int OUT_W      = 48;
   localparam int SIZE_W     = 7;
   localparam int EXP_W      = 32;
   localparam int BITPOS_W   = $clog2(EXP_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT    = 1'd1;

   typedef logic [1:0] bank_type;
   localparam bank_type BANK_A    = 2'd0;
   localparam bank_type BANK_B    = 2'd1;
   localparam bank_type BANK_C    = 2'd2;
   localparam bank_type BANK_BASE = 2'd3;
endpackage

// File: design/mmpmp_if.sv
// Interfaces: request and response channels of the matrix power block.
`timescale 1ns / 1ps
interface mmpmp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [mmpmp_pkg::IDX_W-1:0]          row;
   logic [mmpmp_pkg::IDX_W-1:0]          col;
   logic [mmpmp_pkg::WEIGHT_W-1:0]       weight;
   logic                                 linked;
   modport source (output valid, cmd, row, col, weight, linked, input ready);
   modport sink (input valid, cmd, row, col, weight, linked, output ready);
endinterface

interface mmpmp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mmpmp_pkg::OUT_W-1:0]          best_value;
   modport source (output valid, best_value, input ready);
   modport sink (input valid, best_value, output ready);
endinterface

// File: design/masked_max_plus_matrix_power.sv
// Top level: masked max-plus matrix power with load, run and result channels.
//
// channel   dir  handshake          payload
// req_chan  in   valid/ready        cmd, row, col, weight, linked
// rsp_chan  out  valid/ready        best_value
// csr_*     in   csr_we             csr_index, csr_wdata
//
// After reset a clearing pass zeroes every cell of the base matrix; req is not ready meanwhile.
// A load item is written as it is accepted. A run first finds the top set exponent bit t, then
// for each lower bit passes a step state and one or two max-plus products on the shared add/compare
// unit, then one more step state, a scan for the largest entry and the result.
// One item is worked on at a time; a finished result waits in the output register while
// loads are taken, and a second finished run holds the input until that register frees.
`timescale 1ns / 1ps
module masked_max_plus_matrix_power (
   input  logic                                clock,
   input  logic                                reset,
   mmpmp_req_if.sink                           req_chan,
   mmpmp_rsp_if.source                         rsp_chan,
   input  logic                                csr_we,
   input  logic [mmpmp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmpmp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_FIND, ST_STEP, ST_PROD, ST_DRAIN,
      ST_SCAN, ST_SDRAIN, ST_OUT
   } state_type;

   localparam int AW = mmpmp_pkg::ADDR_W;
   localparam int IW = mmpmp_pkg::IDX_W;
   localparam int VW = mmpmp_pkg::VALUE_BITS;

   state_type                        state_ff;
   logic [AW-1:0]                    clr_ff;
   logic [mmpmp_pkg::SIZE_W-1:0]     size_ff;
   logic [mmpmp_pkg::EXP_W-1:0]      exp_ff;
   logic [mmpmp_pkg::EXP_W-1:0]      e_ff;
   logic [mmpmp_pkg::BITPOS_W-1:0]   bitpos_ff;
   logic [IW-1:0]                    last_ff;
   logic [IW-1:0]                    i_ff, j_ff, k_ff;
   logic                             first_ff;
   logic                             second_ff;
   mmpmp_pkg::bank_type              run_ff, xb_ff, yb_ff, ob_ff, pr_ff;
   logic                             p_valid_ff, p_first_ff, p_last_ff, s_valid_ff;
   logic [AW-1:0]                    p_waddr_ff;
   logic [VW-1:0]                    acc_ff;
   logic [mmpmp_pkg::OUT_W-1:0]      best_ff;
   logic                             rsp_valid_ff;
   logic [mmpmp_pkg::OUT_W-1:0]      rsp_data_ff;

   logic [VW-1:0]                    bank_a [mmpmp_pkg::CELLS];
   logic [VW-1:0]                    bank_b [mmpmp_pkg::CELLS];
   logic [VW-1:0]                    bank_c [mmpmp_pkg::CELLS];
   logic [mmpmp_pkg::WEIGHT_W-1:0]   base_mem [mmpmp_pkg::CELLS];
   logic                             link_mem [mmpmp_pkg::CELLS];

   logic [VW-1:0]                    ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [mmpmp_pkg::WEIGHT_W-1:0]   basex_ff, basey_ff;
   logic                             lka_ff, lkb_ff;

   logic [AW-1:0]                    xa_in, ya_in, la_in, lb_in;
   logic [VW-1:0]                    xd_in, yd_in, acc_in;
   logic [VW:0]                      sum_in;
   logic [VW-1:0]                    sat_in;
   logic                             wr_in;
   logic                             base_we_in;
   logic [AW-1:0]                    base_wa_in;
   logic [mmpmp_pkg::WEIGHT_W-1:0]   base_wd_in;
   logic                             link_wd_in;
   logic [mmpmp_pkg::SIZE_W-1:0]     n_in;
   logic [mmpmp_pkg::EXP_W-1:0]      eeff_in;
   logic                             req_acc_in;
   mmpmp_pkg::bank_type              sc_in, pr_in;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign req_acc_in           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.best_value  = rsp_data_ff;

   assign n_in    = (size_ff > mmpmp_pkg::SIZE_W'(mmpmp_pkg::MAX_SIZE))
                    ? mmpmp_pkg::SIZE_W'(mmpmp_pkg::MAX_SIZE) : size_ff;
   assign eeff_in = (exp_ff == '0) ? mmpmp_pkg::EXP_W'(1) : exp_ff;

   always_comb begin
      case (run_ff)
         mmpmp_pkg::BANK_A: begin sc_in = mmpmp_pkg::BANK_B; pr_in = mmpmp_pkg::BANK_C; end
         mmpmp_pkg::BANK_B: begin sc_in = mmpmp_pkg::BANK_A; pr_in = mmpmp_pkg::BANK_C; end
         mmpmp_pkg::BANK_C: begin sc_in = mmpmp_pkg::BANK_A; pr_in = mmpmp_pkg::BANK_B; end
         default:           begin sc_in = mmpmp_pkg::BANK_A; pr_in = mmpmp_pkg::BANK_B; end
      endcase
   end

   // read addresses: x[i][j] on the first beat, then x[i][k] and y[k][j]
   always_comb begin
      xa_in = first_ff ? {i_ff, j_ff} : {i_ff, k_ff};
      if (state_ff == ST_SCAN) begin
         xa_in = {i_ff, j_ff};
      end
      ya_in = {k_ff, j_ff};
      la_in = {i_ff, k_ff};
      lb_in = {k_ff, j_ff};
   end

   always_comb begin
      case (xb_ff)
         mmpmp_pkg::BANK_A: xd_in = ax_ff;
         mmpmp_pkg::BANK_B: xd_in = bx_ff;
         mmpmp_pkg::BANK_C: xd_in = cx_ff;
         default:           xd_in = VW'(basex_ff);
      endcase
      case (yb_ff)
         mmpmp_pkg::BANK_A: yd_in = ay_ff;
         mmpmp_pkg::BANK_B: yd_in = by_ff;
         mmpmp_pkg::BANK_C: yd_in = cy_ff;
         default:           yd_in = VW'(basey_ff);
      endcase
      sum_in = {1'b0, xd_in} + {1'b0, yd_in};
      sat_in = sum_in[VW] ? {VW{1'b1}} : sum_in[VW-1:0];
      if (p_first_ff) begin
         acc_in = xd_in;
      end else if (lka_ff && lkb_ff && (sat_in > acc_ff)) begin
         acc_in = sat_in;
      end else begin
         acc_in = acc_ff;
      end
      wr_in = p_valid_ff && p_last_ff;
   end

   always_comb begin
      base_we_in = 1'b0;
      base_wa_in = {req_chan.row, req_chan.col};
      base_wd_in = req_chan.weight;
      link_wd_in = req_chan.linked;
      if (state_ff == ST_CLEAR) begin
         base_we_in = 1'b1;
         base_wa_in = clr_ff;
         base_wd_in = '0;
         link_wd_in = 1'b0;
      end else if (req_acc_in && (req_chan.cmd == mmpmp_pkg::CMD_LOAD)) begin
         base_we_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (base_we_in) begin
         base_mem[base_wa_in] <= base_wd_in;
         link_mem[base_wa_in] <= link_wd_in;
      end
      basex_ff <= base_mem[xa_in];
      basey_ff <= base_mem[ya_in];
      lka_ff   <= link_mem[la_in];
      lkb_ff   <= link_mem[lb_in];
   end

   always_ff @(posedge clock) begin
      if (wr_in && (ob_ff == mmpmp_pkg::BANK_A)) begin
         bank_a[p_waddr_ff] <= acc_in;
      end
      ax_ff <= bank_a[xa_in];
      ay_ff <= bank_a[ya_in];
   end

   always_ff @(posedge clock) begin
      if (wr_in && (ob_ff == mmpmp_pkg::BANK_B)) begin
         bank_b[p_waddr_ff] <= acc_in;
      end
      bx_ff <= bank_b[xa_in];
      by_ff <= bank_b[ya_in];
   end

   always_ff @(posedge clock) begin
      if (wr_in && (ob_ff == mmpmp_pkg::BANK_C)) begin
         bank_c[p_waddr_ff] <= acc_in;
      end
      cx_ff <= bank_c[xa_in];
      cy_ff <= bank_c[ya_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= mmpmp_pkg::SIZE_W'(1);
         exp_ff       <= mmpmp_pkg::EXP_W'(1);
         bitpos_ff    <= '0;
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
         second_ff    <= 1'b0;
         run_ff       <= mmpmp_pkg::BANK_BASE;
         xb_ff        <= mmpmp_pkg::BANK_BASE;
         yb_ff        <= mmpmp_pkg::BANK_BASE;
         ob_ff        <= mmpmp_pkg::BANK_A;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mmpmp_pkg::CSR_MATRIX_SIZE: size_ff <= csr_wdata[mmpmp_pkg::SIZE_W-1:0];
               mmpmp_pkg::CSR_EXPONENT:    exp_ff  <= csr_wdata[mmpmp_pkg::EXP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         if (p_valid_ff) begin
            acc_ff <= acc_in;
         end
         if (s_valid_ff && (xd_in > best_ff)) begin
            best_ff <= xd_in;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == {AW{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_acc_in && (req_chan.cmd == mmpmp_pkg::CMD_RUN)) begin
                  e_ff      <= eeff_in;
                  last_ff   <= IW'(n_in - 1'b1);
                  bitpos_ff <= mmpmp_pkg::BITPOS_W'(mmpmp_pkg::EXP_W - 1);
                  run_ff    <= mmpmp_pkg::BANK_BASE;
                  best_ff   <= '0;
                  state_ff  <= (n_in == '0) ? ST_OUT : ST_FIND;
               end
            end
            ST_FIND: begin
               if ((bitpos_ff != '0) && !e_ff[bitpos_ff]) begin
                  bitpos_ff <= bitpos_ff - 1'b1;
               end else begin
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               i_ff     <= '0;
               j_ff     <= '0;
               k_ff     <= '0;
               first_ff <= 1'b1;
               xb_ff    <= run_ff;
               if (bitpos_ff == '0) begin
                  state_ff <= ST_SCAN;
               end else begin
                  bitpos_ff <= bitpos_ff - 1'b1;
                  pr_ff     <= pr_in;
                  if (e_ff[bitpos_ff - 1'b1]) begin
                     second_ff <= 1'b1;
                     yb_ff     <= mmpmp_pkg::BANK_BASE;
                     ob_ff     <= sc_in;
                  end else begin
                     second_ff <= 1'b0;
                     yb_ff     <= run_ff;
                     ob_ff     <= pr_in;
                  end
                  state_ff <= ST_PROD;
               end
            end
            ST_PROD: begin
               p_valid_ff <= 1'b1;
               p_first_ff <= first_ff;
               p_last_ff  <= !first_ff && (k_ff == last_ff);
               p_waddr_ff <= {i_ff, j_ff};
               if (first_ff) begin
                  first_ff <= 1'b0;
                  k_ff     <= '0;
               end else if (k_ff != last_ff) begin
                  k_ff <= k_ff + 1'b1;
               end else begin
                  first_ff <= 1'b1;
                  if (j_ff != last_ff) begin
                     j_ff <= j_ff + 1'b1;
                  end else begin
                     j_ff <= '0;
                     if (i_ff != last_ff) begin
                        i_ff <= i_ff + 1'b1;
                     end else begin
                        i_ff     <= '0;
                        state_ff <= ST_DRAIN;
                     end
                  end
               end
            end
            ST_DRAIN: begin
               if (second_ff) begin
                  second_ff <= 1'b0;
                  yb_ff     <= ob_ff;
                  ob_ff     <= pr_ff;
                  first_ff  <= 1'b1;
                  state_ff  <= ST_PROD;
               end else begin
                  run_ff   <= ob_ff;
                  state_ff <= ST_STEP;
               end
            end
            ST_SCAN: begin
               s_valid_ff <= 1'b1;
               if (j_ff != last_ff) begin
                  j_ff <= j_ff + 1'b1;
               end else begin
                  j_ff <= '0;
                  if (i_ff != last_ff) begin
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     state_ff <= ST_SDRAIN;
                  end
               end
            end
            ST_SDRAIN: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= best_ff;
                  bitpos_ff    <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

// File: test/tb_masked_max_plus_matrix_power.sv
// Testbench: masked max-plus matrix power, directed table plus random loads and runs.
`timescale 1ns / 1ps
module tb_masked_max_plus_matrix_power;
   localparam logic [mmpmp_pkg::VALUE_BITS-1:0] SUM_MAX = {mmpmp_pkg::VALUE_BITS{1'b1}};

   typedef enum logic [1:0] {K_LOAD, K_RUN, K_CSR} step_kind_type;
   typedef struct packed {
      step_kind_type                        kind;
      logic [mmpmp_pkg::IDX_W-1:0]          r;
      logic [mmpmp_pkg::IDX_W-1:0]          c;
      logic [mmpmp_pkg::WEIGHT_W-1:0]       w;
      logic                                 l;
      logic [mmpmp_pkg::CSR_IDX_W-1:0]      csr_idx;
      logic [mmpmp_pkg::CSR_DATA_W-1:0]     csr_data;
      logic                                 typed;
      logic [mmpmp_pkg::OUT_W-1:0]          want;
   } step_type;
   typedef longint unsigned mat_type [mmpmp_pkg::MAX_SIZE][mmpmp_pkg::MAX_SIZE];

   localparam int NSTEPS = 24;
   step_type script [NSTEPS] = '{
      '{K_RUN,  0, 0, 0, 0, 0, 0, 1, 0},
      '{K_LOAD, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0},
      '{K_RUN,  0, 0, 0, 0, 0, 0, 1, 65535},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_EXPONENT, 0, 0, 0},
      '{K_RUN,  0, 0, 0, 0, 0, 0, 1, 65535},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_EXPONENT, 2, 0, 0},
      '{K_RUN,  0, 0, 0, 0, 0, 0, 1, 131070},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_MATRIX_SIZE, 0, 0, 0},
      '{K_RUN,  6'h3F, 6'h3F, 16'hFFFF, 1, 0, 0, 1, 0},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_MATRIX_SIZE, 127, 0, 0},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_EXPONENT, 1, 0, 0},
      '{K_LOAD, 63, 63, 16'hFFFF, 0, 0, 0, 0, 0},
      '{K_LOAD, 63, 0, 1, 1, 0, 0, 0, 0},
      '{K_RUN,  0, 0, 0, 0, 0, 0, 1, 65535},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_MATRIX_SIZE, 3, 0, 0},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_EXPONENT, 32'hFFFF_FFFF, 0, 0},
      '{K_LOAD, 0, 1, 16'hFFFF, 1, 0, 0, 0, 0},
      '{K_LOAD, 1, 2, 16'hFFFF, 1, 0, 0, 0, 0},
      '{K_LOAD, 2, 0, 16'hFFFF, 1, 0, 0, 0, 0},
      '{K_RUN,  0, 0, 0, 0, 0, 0, 0, 0},
      '{K_LOAD, 2, 2, 0, 0, 0, 0, 0, 0},
      '{K_LOAD, 5, 5, 12345, 1, 0, 0, 0, 0},
      '{K_RUN,  0, 0, 0, 0, 0, 0, 0, 0},
      '{K_CSR,  0, 0, 0, 0, mmpmp_pkg::CSR_MATRIX_SIZE, 6, 0, 0}
   };

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [mmpmp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mmpmp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   mmpmp_req_if req_if();
   mmpmp_rsp_if rsp_if();

   masked_max_plus_matrix_power uut (
      .clock(clock), .reset(reset), .req_chan(req_if), .rsp_chan(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [mmpmp_pkg::WEIGHT_W-1:0] weight_mem [mmpmp_pkg::MAX_SIZE][mmpmp_pkg::MAX_SIZE];
   bit                             link_mem [mmpmp_pkg::MAX_SIZE][mmpmp_pkg::MAX_SIZE];
   logic [mmpmp_pkg::SIZE_W-1:0]   size_reg;
   logic [mmpmp_pkg::EXP_W-1:0]    exp_reg;

   logic [mmpmp_pkg::OUT_W-1:0] best_pending [$];
   int mismatches = 0;
   int runs_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   mat_type cur, tmp, prod;

   function automatic void maxplus(output mat_type p, input mat_type x, input mat_type y,
                                   input int n);
      longint unsigned v, s;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            v = x[i][j];
            for (int k = 0; k < n; k++)
               if (link_mem[i][k] && link_mem[k][j]) begin
                  s = x[i][k] + y[k][j];
                  if (s > SUM_MAX) s = SUM_MAX;
                  if (s > v) v = s;
               end
            p[i][j] = v;
         end
   endfunction

   function automatic logic [mmpmp_pkg::OUT_W-1:0] power_best();
      int n, top;
      logic [mmpmp_pkg::EXP_W-1:0] e;
      longint unsigned best;
      n = (size_reg > mmpmp_pkg::MAX_SIZE) ? mmpmp_pkg::MAX_SIZE : size_reg;
      e = (exp_reg == 0) ? 1 : exp_reg;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) cur[i][j] = 64'(weight_mem[i][j]);
      top = 31;
      while (top > 0 && !e[top]) top--;
      for (int b = top - 1; b >= 0; b--) begin
         if (e[b]) begin
            for (int i = 0; i < n; i++)
               for (int j = 0; j < n; j++) tmp[i][j] = 64'(weight_mem[i][j]);
            maxplus(prod, cur, tmp, n);
            tmp = prod;
            maxplus(prod, cur, tmp, n);
         end else begin
            maxplus(prod, cur, cur, n);
         end
         cur = prod;
      end
      best = 0;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (cur[i][j] > best) best = cur[i][j];
      return best[mmpmp_pkg::OUT_W-1:0];
   endfunction

   // receiver
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [mmpmp_pkg::OUT_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (best_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: best_value %0d", rsp_if.best_value);
         end else begin
            want = best_pending.pop_front();
            if (rsp_if.best_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("best_value: expected %0d got %0d", want, rsp_if.best_value);
            end
         end
      end
   end

   task automatic send(input logic cmd, input logic [mmpmp_pkg::IDX_W-1:0] r,
                       input logic [mmpmp_pkg::IDX_W-1:0] c,
                       input logic [mmpmp_pkg::WEIGHT_W-1:0] w, input logic l, input bit typed,
                       input logic [mmpmp_pkg::OUT_W-1:0] want);
      while ($urandom_range(1, 100) <= idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.row <= r;
      req_if.col <= c;
      req_if.weight <= w;
      req_if.linked <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (cmd == mmpmp_pkg::CMD_LOAD) begin
         weight_mem[r][c] = w;
         link_mem[r][c] = l;
      end else begin
         runs_sent++;
         best_pending.push_back(typed ? want : power_best());
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (best_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mmpmp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mmpmp_pkg::CSR_DATA_W-1:0] data);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mmpmp_pkg::CSR_MATRIX_SIZE) size_reg = data[mmpmp_pkg::SIZE_W-1:0];
      else exp_reg = data;
   endtask

   task automatic random_item();
      logic [mmpmp_pkg::IDX_W-1:0] r, c;
      logic [mmpmp_pkg::WEIGHT_W-1:0] w;
      if ($urandom_range(1, 100) <= 15) begin
         send(mmpmp_pkg::CMD_RUN, mmpmp_pkg::IDX_W'($urandom), mmpmp_pkg::IDX_W'($urandom),
              mmpmp_pkg::WEIGHT_W'($urandom), 1'($urandom), 0, 0);
      end else begin
         r = mmpmp_pkg::IDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 5));
         c = mmpmp_pkg::IDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 5));
         case ($urandom_range(0, 5))
            0: w = 0;
            1: w = 16'hFFFF;
            default: w = mmpmp_pkg::WEIGHT_W'($urandom);
         endcase
         send(mmpmp_pkg::CMD_LOAD, r, c, w, $urandom_range(0, 3) != 0, 0, 0);
      end
   endtask

   initial begin
      step_type s;
      logic [mmpmp_pkg::CSR_DATA_W-1:0] ex;
      req_if.valid = 0;
      req_if.cmd = mmpmp_pkg::CMD_LOAD;
      req_if.row = 0;
      req_if.col = 0;
      req_if.weight = 0;
      req_if.linked = 0;
      rsp_if.ready = 0;
      size_reg = 1;
      exp_reg = 1;
      for (int i = 0; i < mmpmp_pkg::MAX_SIZE; i++)
         for (int j = 0; j < mmpmp_pkg::MAX_SIZE; j++) begin
            weight_mem[i][j] = 0;
            link_mem[i][j] = 0;
         end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int t = 0; t < NSTEPS; t++) begin
         s = script[t];
         if (s.kind == K_CSR) write_csr(s.csr_idx, s.csr_data);
         else send(s.kind == K_RUN ? mmpmp_pkg::CMD_RUN : mmpmp_pkg::CMD_LOAD,
                   s.r, s.c, s.w, s.l, s.typed, s.want);
      end
      send(mmpmp_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0);

      for (int ph = 0; ph < 8 || runs_sent < 60; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         write_csr(mmpmp_pkg::CSR_MATRIX_SIZE,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4));
         case ($urandom_range(0, 3))
            0: ex = $urandom;
            1: ex = 32'h8000_0000 | $urandom;
            default: ex = $urandom_range(0, 12);
         endcase
         write_csr(mmpmp_pkg::CSR_EXPONENT, ex);
         if (ph == 0) hold_left = 40000;
         for (int k = 0; k < 75; k++) begin
            if (ph == 4 && k == 40) drain();
            random_item();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #500ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: sim.f
design/mmpmp_pkg.sv
design/mmpmp_if.sv
design/masked_max_plus_matrix_power.sv
test/tb_masked_max_plus_matrix_power.sv
